// ----- rtl/psh_pkg.sv -----
// Package for the path switch hysteresis block: widths, codes and item layouts.
package psh_pkg;

    localparam int TICK_BITS = 8;
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // held path / mode codes, NONE only before the first choice
    localparam logic [1:0] PATH_FIRST = 2'd0;
    localparam logic [1:0] PATH_SECOND = 2'd1;
    localparam logic [1:0] PATH_NONE = 2'd2;
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_EMERGENCY = 2'd1;
    localparam logic [1:0] MODE_NONE = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLEARANCE_FLOOR = 3'd0,
        REG_LAT_ACCEL_LIMIT = 3'd1,
        REG_HOLD_TICKS = 3'd2,
        REG_SCORE_MARGIN = 3'd3,
        REG_TIE_BAND = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] lat_accel_second;
        logic [15:0] lat_accel_first;
        logic [15:0] clearance_second;
        logic [15:0] clearance_first;
        logic signed [15:0] score_second;
        logic signed [15:0] score_first;
    } in_item_t;

    typedef struct packed {
        logic [3:0] pad;
        logic [15:0] chosen_clearance;
        logic mode_switched;
        logic path_switched;
        logic drive_mode;
        logic chosen_path;
    } out_item_t;

endpackage

// ----- rtl/planner_switch_hysteresis.sv -----
// Path selector with hysteresis for two candidate paths, one decision per control tick.
//
// Usage:
//   s_* channel: one control tick per transfer, carrying score, clearance and
//   lateral acceleration of both candidate paths. m_* channel: one result per
//   tick with the chosen path, drive mode, switch flags and chosen clearance.
//   cfg_* channel: register writes (index 0..4), always ready; write only while
//   no ticks are in flight.
//   An accepted tick is held in the input register, and its result in the
//   result register that drives m_tdata. Throughput: one tick per cycle while
//   m_tready stays high; the two registers form a two-entry pipeline, and the
//   decision and the held path, mode and tick counter update lie between them.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more tick, then s_tready drops until m_tready returns.
//   Reset (aresetn low, synchronous) empties both registers, restores the
//   default configuration and forgets the held path, so the first result
//   after reset always reports both path and mode as switched.
module planner_switch_hysteresis
    import psh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // score_first, score_second, clearance_first, clearance_second,
    // lat_accel_first, lat_accel_second (16 bits each, from bit 0 up)
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // chosen_path, drive_mode, path_switched, mode_switched,
    // chosen_clearance[15:0], zero padding (from bit 0 up)
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [15:0] clearance_floor_reg;
    logic [15:0] lat_accel_limit_reg;
    logic [7:0]  hold_ticks_reg;
    logic [14:0] score_margin_reg;
    logic [15:0] tie_band_reg;

    logic [1:0]           held_path_reg, held_path_next;
    logic [1:0]           held_mode_reg, held_mode_next;
    logic [TICK_BITS-1:0] ticks_reg, ticks_next;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg, out_item_next;

    logic advance;

    logic [TICK_BITS-1:0] ticks_inc;
    logic                 safe_first, safe_second;
    logic                 score_first_wins;
    logic                 cand_path, cand_mode;
    logic signed [17:0]   cand_score, held_score_margin;
    logic                 hold;
    logic                 path_switched;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearance_floor_reg <= 16'd150;
            lat_accel_limit_reg <= 16'd7000;
            hold_ticks_reg      <= 8'd6;
            score_margin_reg    <= 15'd38;
            tie_band_reg        <= 16'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CLEARANCE_FLOOR: clearance_floor_reg <= cfg_data;
                REG_LAT_ACCEL_LIMIT: lat_accel_limit_reg <= cfg_data;
                REG_HOLD_TICKS:      hold_ticks_reg      <= cfg_data[7:0];
                REG_SCORE_MARGIN:    score_margin_reg    <= cfg_data[14:0];
                REG_TIE_BAND:        tie_band_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // decision for the tick sitting in the input register
    always_comb begin
        ticks_inc = (ticks_reg < TICK_MAX) ? ticks_reg + 1'b1 : ticks_reg;

        safe_first  = (in_item_reg.clearance_first >= clearance_floor_reg)
                   && (in_item_reg.lat_accel_first <= lat_accel_limit_reg);
        safe_second = (in_item_reg.clearance_second >= clearance_floor_reg)
                   && (in_item_reg.lat_accel_second <= lat_accel_limit_reg);
        score_first_wins = (in_item_reg.score_first >= in_item_reg.score_second);

        if (safe_first && safe_second) begin
            cand_mode = MODE_NORMAL[0];
            cand_path = !score_first_wins;
        end else begin
            cand_mode = MODE_EMERGENCY[0];
            if (safe_first) begin
                cand_path = PATH_FIRST[0];
            end else if (safe_second) begin
                cand_path = PATH_SECOND[0];
            end else if ({1'b0, in_item_reg.clearance_first} >
                         {1'b0, in_item_reg.clearance_second} + {1'b0, tie_band_reg}) begin
                cand_path = PATH_FIRST[0];
            end else if ({1'b0, in_item_reg.clearance_second} >
                         {1'b0, in_item_reg.clearance_first} + {1'b0, tie_band_reg}) begin
                cand_path = PATH_SECOND[0];
            end else begin
                cand_path = !score_first_wins;
            end
        end

        cand_score = cand_path ? 18'(in_item_reg.score_second) : 18'(in_item_reg.score_first);
        held_score_margin = (held_path_reg[0] ? 18'(in_item_reg.score_second)
                                              : 18'(in_item_reg.score_first))
                          + $signed({3'b000, score_margin_reg});

        hold = 1'b0;
        if (held_path_reg != PATH_NONE && {1'b0, cand_path} != held_path_reg) begin
            if ({8'd0, ticks_inc} < {{TICK_BITS{1'b0}}, hold_ticks_reg}) begin
                hold = 1'b1;
            end else if (cand_score < held_score_margin) begin
                hold = 1'b1;
            end
        end

        held_path_next = hold ? held_path_reg : {1'b0, cand_path};
        held_mode_next = hold ? held_mode_reg : {1'b0, cand_mode};
        path_switched  = (held_path_next != held_path_reg);
        ticks_next     = path_switched ? '0 : ticks_inc;

        out_item_next.pad              = '0;
        out_item_next.chosen_path      = held_path_next[0];
        out_item_next.drive_mode       = held_mode_next[0];
        out_item_next.path_switched    = path_switched;
        out_item_next.mode_switched    = (held_mode_next != held_mode_reg);
        out_item_next.chosen_clearance = held_path_next[0] ? in_item_reg.clearance_second
                                                           : in_item_reg.clearance_first;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_path_reg <= PATH_NONE;
            held_mode_reg <= MODE_NONE;
            ticks_reg     <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                held_path_reg <= held_path_next;
                held_mode_reg <= held_mode_next;
                ticks_reg     <= ticks_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_t'(s_tdata);
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed tick did not produce a result");

    a_switch_clears_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && path_switched |=> ticks_reg == '0)
        else $error("tick counter not cleared on path switch");

    a_held_codes_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_path_reg == PATH_NONE) == (held_mode_reg == MODE_NONE))
        else $error("held path and held mode disagree on none state");

    a_hold_window: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && held_path_reg != PATH_NONE
        && {8'd0, ticks_inc} < {{TICK_BITS{1'b0}}, hold_ticks_reg} |-> !path_switched)
        else $error("path switched inside the hold window");

    a_stall_keeps_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && !s_tready == (out_valid_reg && !m_tready))
        else $error("pending tick lost during stall");

endmodule

// ----- tb/tb_planner_switch_hysteresis.sv -----
// Self-checking testbench for the two-path selector with switch hysteresis.
`timescale 1ns / 1ps

module tb_planner_switch_hysteresis;
    import psh_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // mirror of the configuration and of the held decision
    logic [15:0]          floor_q = 16'd150;
    logic [15:0]          accel_lim_q = 16'd7000;
    logic [7:0]           hold_q = 8'd6;
    logic [14:0]          margin_q = 15'd38;
    logic [15:0]          tie_q = 16'd1;
    logic [1:0]           held_path_q = PATH_NONE;
    logic [1:0]           held_mode_q = MODE_NONE;
    logic [TICK_BITS-1:0] ticks_q = '0;

    out_item_t decisions_due [$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        quiet_cycles = 0;
    bit        calm = 1'b0;
    bit        hold_off_req = 1'b0;

    planner_switch_hysteresis dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // One control tick: pick a candidate, apply hysteresis, update the held state.
    function automatic out_item_t decide_path(in_item_t t);
        int         sc [2];
        int         cl [2];
        bit         safe [2];
        logic [1:0] cand_path;
        logic [1:0] cand_mode;
        logic [1:0] out_path;
        logic [1:0] out_mode;
        bit         keep;
        out_item_t  r;
        sc[0] = int'($signed(t.score_first));
        sc[1] = int'($signed(t.score_second));
        cl[0] = int'(t.clearance_first);
        cl[1] = int'(t.clearance_second);
        if (ticks_q != TICK_MAX)
            ticks_q = ticks_q + 1'b1;
        safe[0] = t.clearance_first >= floor_q && t.lat_accel_first <= accel_lim_q;
        safe[1] = t.clearance_second >= floor_q && t.lat_accel_second <= accel_lim_q;
        if (safe[0] && safe[1]) begin
            cand_mode = MODE_NORMAL;
            cand_path = (sc[0] >= sc[1]) ? PATH_FIRST : PATH_SECOND;
        end else begin
            cand_mode = MODE_EMERGENCY;
            if (safe[0])
                cand_path = PATH_FIRST;
            else if (safe[1])
                cand_path = PATH_SECOND;
            else if (cl[0] > cl[1] + int'(tie_q))
                cand_path = PATH_FIRST;
            else if (cl[1] > cl[0] + int'(tie_q))
                cand_path = PATH_SECOND;
            else
                cand_path = (sc[0] >= sc[1]) ? PATH_FIRST : PATH_SECOND;
        end
        keep = 1'b0;
        if (held_path_q != PATH_NONE && cand_path != held_path_q) begin
            if (ticks_q < hold_q)
                keep = 1'b1;
            else if (sc[cand_path[0]] < sc[held_path_q[0]] + int'(margin_q))
                keep = 1'b1;
        end
        out_path = keep ? held_path_q : cand_path;
        out_mode = keep ? held_mode_q : cand_mode;
        r = '0;
        r.chosen_path = out_path[0];
        r.drive_mode = out_mode[0];
        r.path_switched = (out_path != held_path_q);
        r.mode_switched = (out_mode != held_mode_q);
        r.chosen_clearance = 16'(cl[out_path[0]]);
        if (out_path != held_path_q)
            ticks_q = '0;
        held_path_q = out_path;
        held_mode_q = out_mode;
        return r;
    endfunction

    function automatic in_item_t mk(int s0, int s1, int c0, int c1, int a0, int a1);
        in_item_t t;
        t.score_first = 16'(s0);
        t.score_second = 16'(s1);
        t.clearance_first = 16'(c0);
        t.clearance_second = 16'(c1);
        t.lat_accel_first = 16'(a0);
        t.lat_accel_second = 16'(a1);
        return t;
    endfunction

    function automatic out_item_t res(bit path, bit mode, bit psw, bit msw, int clr);
        out_item_t r;
        r = '0;
        r.chosen_path = path;
        r.drive_mode = mode;
        r.path_switched = psw;
        r.mode_switched = msw;
        r.chosen_clearance = 16'(clr);
        return r;
    endfunction

    // mostly close to a threshold, sometimes anywhere or at the rails
    function automatic logic [15:0] near_or_wild(logic [15:0] center);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5:
                return 16'(clamp(int'(center) + int'($urandom_range(6)) - 3, 0, 65535));
            6, 7: return 16'($urandom);
            8: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic int rand_score();
        case ($urandom_range(9))
            0, 1, 2: return int'($signed(16'($urandom)));
            3: return -32768;
            4: return 32767;
            default: return int'($urandom_range(1200)) - 600;
        endcase
    endfunction

    function automatic in_item_t gen_tick();
        in_item_t t;
        int       s0;
        int       s1;
        int       c0;
        s0 = rand_score();
        case ($urandom_range(4))
            0: s1 = s0;
            1, 2: s1 = clamp(s0 + ($urandom_range(1) ? 1 : -1) * int'(margin_q)
                             + int'($urandom_range(6)) - 3, -32768, 32767);
            default: s1 = rand_score();
        endcase
        c0 = int'(near_or_wild(floor_q));
        t.score_first = 16'(s0);
        t.score_second = 16'(s1);
        t.clearance_first = 16'(c0);
        // second clearance often sits on the edge of the tie band
        if ($urandom_range(2) == 0)
            t.clearance_second = 16'(clamp(c0 + ($urandom_range(1) ? 1 : -1) * int'(tie_q)
                                           + int'($urandom_range(2)) - 1, 0, 65535));
        else
            t.clearance_second = near_or_wild(floor_q);
        t.lat_accel_first = near_or_wild(accel_lim_q);
        t.lat_accel_second = near_or_wild(accel_lim_q);
        return t;
    endfunction

    function automatic void note_mismatch(string what);
        if (mismatches < 10)
            $display("mismatch at result %0d: %s", results_seen, what);
        mismatches++;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_tick(input in_item_t t, input bit typed, input out_item_t typed_res);
        out_item_t predicted;
        while (!calm && $urandom_range(99) < 38) begin
            s_tvalid = 1'b0;
            s_tdata = {$urandom, $urandom, $urandom};
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = t;
        do @(posedge aclk); while (!s_tready);
        predicted = decide_path(t);
        decisions_due = {decisions_due, (typed ? typed_res : predicted)};
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CLEARANCE_FLOOR: floor_q = val;
            REG_LAT_ACCEL_LIMIT: accel_lim_q = val;
            REG_HOLD_TICKS: hold_q = val[7:0];
            REG_SCORE_MARGIN: margin_q = val[14:0];
            REG_TIE_BAND: tie_q = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // wait until every decision has come back, then let the pipeline settle
    task automatic wait_drain();
        while (decisions_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    // receiver: random back-pressure plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = calm || ($urandom_range(99) >= 38);
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t got;
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = out_item_t'(m_tdata);
            if (decisions_due.size() == 0) begin
                note_mismatch("result transfer with no decision pending");
            end else begin
                want = decisions_due.pop_front();
                check_field("chosen_path", 16'(want.chosen_path), 16'(got.chosen_path));
                check_field("drive_mode", 16'(want.drive_mode), 16'(got.drive_mode));
                check_field("path_switched", 16'(want.path_switched), 16'(got.path_switched));
                check_field("mode_switched", 16'(want.mode_switched), 16'(got.mode_switched));
                check_field("chosen_clearance", want.chosen_clearance, got.chosen_clearance);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        dir_row_t dir_table [21];
        int       ph_cfg [6][5];
        int       ph_len [6];
        ph_cfg = '{
            '{500, 3000, 3, 100, 50},
            '{0, 0, 0, 0, 0},
            '{65535, 65535, 65535, 65535, 65535},  // hold and margin wrap to their widths
            '{150, 7000, 2, 10, 20},
            '{0, 0, 0, 0, 0},
            '{1000, 20000, 16'hFF00, 16'h8000, 300}
        };
        ph_len = '{120, 100, 280, 150, 120, 80};

        // defaults apply: floor 150, limit 7000, hold 6, margin 38, tie band 1
        dir_table = '{
            // first choice after reset reports both switches
            '{mk(0, 0, 200, 300, 0, 0), 1'b1, res(0, 0, 1, 1, 200)},
            '{mk(0, 0, 200, 300, 0, 0), 1'b1, res(0, 0, 0, 0, 200)},
            '{mk(32767, -32768, 65535, 0, 7000, 65535), 1'b0, '0},
            '{mk(-32768, 32767, 150, 65535, 0, 0), 1'b0, '0},
            '{mk(0, 0, 149, 149, 0, 0), 1'b0, '0},
            '{mk(0, 100, 148, 150, 7001, 0), 1'b0, '0},
            '{mk(0, 0, 0, 0, 65535, 65535), 1'b0, '0},
            '{mk(-5, 5, 300, 302, 9000, 9000), 1'b0, '0},
            '{mk(5, -5, 302, 300, 9000, 9000), 1'b0, '0},
            '{mk(-5, 5, 301, 300, 9000, 9000), 1'b0, '0},
            // one short of the margin, then exactly the margin
            '{mk(0, 37, 200, 200, 0, 0), 1'b0, '0},
            '{mk(0, 38, 200, 200, 0, 0), 1'b0, '0},
            // held by the tick counter until the hold time has passed
            '{mk(1000, 0, 200, 210, 0, 0), 1'b0, '0},
            '{mk(1000, 0, 200, 210, 0, 0), 1'b0, '0},
            '{mk(1000, 0, 200, 210, 0, 0), 1'b0, '0},
            '{mk(1000, 0, 200, 210, 0, 0), 1'b0, '0},
            '{mk(1000, 0, 200, 210, 0, 0), 1'b0, '0},
            '{mk(1000, 0, 200, 210, 0, 0), 1'b0, '0},
            '{mk(-32768, -32768, 65535, 65535, 65535, 65535), 1'b0, '0},
            '{mk(32767, 32767, 65535, 65535, 0, 0), 1'b0, '0},
            '{mk(-32768, 32767, 0, 65535, 65535, 0), 1'b0, '0}
        };

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_table[i])
            send_tick(dir_table[i].stim, dir_table[i].typed, dir_table[i].want);

        for (int p = 0; p < 6; p++) begin
            s_tvalid = 1'b0;
            wait_drain();
            if (p == 4)
                ph_cfg[4] = '{$urandom_range(2000, 300), $urandom_range(65535),
                              $urandom_range(12, 1), $urandom_range(200),
                              $urandom_range(500)};
            write_reg(REG_CLEARANCE_FLOOR, 16'(ph_cfg[p][0]));
            write_reg(REG_LAT_ACCEL_LIMIT, 16'(ph_cfg[p][1]));
            write_reg(REG_HOLD_TICKS, 16'(ph_cfg[p][2]));
            write_reg(REG_SCORE_MARGIN, 16'(ph_cfg[p][3]));
            write_reg(REG_TIE_BAND, 16'(ph_cfg[p][4]));
            // indexes past the last register must be ignored
            write_reg(CFG_IDX_W'(int'(REG_TIE_BAND) + 1 + p % 3), 16'($urandom));
            cfg_valid = 1'b0;
            for (int n = 0; n < ph_len[p]; n++) begin
                calm = (p == 4 && n < 100);
                if (p == 3 && n == 40)
                    hold_off_req = 1'b1;
                send_tick(gen_tick(), 1'b0, '0);
            end
            calm = 1'b0;
        end

        s_tvalid = 1'b0;
        wait_drain();
        if (mismatches == 0 && decisions_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
